// ===== rtl/cor_pkg.sv =====
// Package for the circle outline rasterizer: codes, constants, job and config types.
// No dependencies; imported by every module of the block.
`default_nettype none
package cor_pkg;

    localparam int COORD_W  = 16;   // centre coordinate width, signed
    localparam int OFFS_W   = 16;   // minor / major offset width
    localparam int DEC_W    = 20;   // decision term width, signed
    localparam int RAD_W    = 15;
    localparam int COLOUR_W = 8;
    localparam int MODE_W   = 2;
    localparam int DIM_W    = 13;   // window / pitch registers
    localparam int PIX_W    = 12;   // in-window column / row
    localparam int POFS_W   = 24;   // pixel offset
    localparam int PT_W     = 3;    // point index within one step
    localparam int PT_LAST  = 7;    // eight symmetric points per step
    localparam int CRD_X_W  = COORD_W + 2;  // centre plus offset, signed

    localparam logic [DIM_W-1:0]  MAX_DIM  = 13'd4096;
    localparam logic [DEC_W-1:0]  DEC_INIT = 20'd3;
    localparam logic [DEC_W-1:0]  DEC_DIAG = 20'd10;
    localparam logic [DEC_W-1:0]  DEC_AXIS = 20'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD   = 2'd3;
    localparam logic [MODE_W-1:0] MODE_OPAQUE = 2'd0;

    typedef enum logic [1:0] {
        REG_BLEND_MODE    = 2'd0,
        REG_WINDOW_WIDTH  = 2'd1,
        REG_WINDOW_HEIGHT = 2'd2,
        REG_SCREEN_PITCH  = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOOP,
        PH_CLOSE,
        PH_SINGLE
    } phase_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [DIM_W-1:0]  pitch;
    } cfg_t;

    // one queued step: either one result (single/blank) or eight points
    typedef struct packed {
        logic                       blank;   // idle answer, never visible
        logic                       single;  // one result only
        logic                       fin;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic [OFFS_W-1:0]          minor;
        logic [OFFS_W-1:0]          major;
        logic [COLOUR_W-1:0]        colour;
        logic [MODE_W-1:0]          mode;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

// ===== rtl/circle_outline_rasterizer.sv =====
// Top level of the circle outline rasterizer: config registers, front end, job queue, back end.
// Depends on cor_pkg, cor_front, cor_queue, cor_back.
//
//  channel   direction  handshake           payload
//  s_        in         s_tvalid/s_tready   s_tuser = op, s_tdata = centre, radius, colour
//  m_        out        m_tvalid/m_tready   m_tuser = visible, m_tdata = offset, colour,
//                                           mode, finished; m_tlast = run_last
//  cfg_      in         cfg_wr_en           cfg_addr = register index, cfg_wdata
//
// Results: a start item gives no result; an advance gives 8 results (1 when idle or for a
// radius of 0 or 1) at one result per cycle while m_tready is high, issued by the point
// sequencer in the back end. The first result of an advance passes through the job queue,
// the point stage register and the output register.
// Reset: synchronous; no clearing pass.
// Stalls: the 2-entry job queue lets the front keep accepting while m_tready is low;
// s_tready drops only when the queue is full.
`default_nettype none
module circle_outline_rasterizer (
    input  wire         aclk,
    input  wire         aresetn,
    // config write port
    input  wire         cfg_wr_en,
    input  wire [1:0]   cfg_addr,
    input  wire [12:0]  cfg_wdata,
    // input items
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [55:0]  s_tdata,   // center_x[15:0], center_y[31:16], circle_radius[46:32],
                                   // pen_colour[54:47], zero pad[55]
    input  wire [0:0]   s_tuser,   // op[0]
    // result items
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // pixel_offset[23:0], out_colour[31:24], out_mode[33:32],
                                   // finished[34], zero pad[39:35]
    output logic [0:0]  m_tuser,   // visible[0]
    output logic        m_tlast    // run_last
);
    import cor_pkg::*;

    cfg_t       cfg_reg;
    q_status_t  q_status;
    logic       push, pop;
    job_t       push_job, head_job;

    logic                 out_visible, out_last, out_fin;
    logic [POFS_W-1:0]    out_offset;
    logic [COLOUR_W-1:0]  out_colour;
    logic [MODE_W-1:0]    out_mode;
    logic [DIM_W-1:0]     dim_sat;

    // window and pitch registers saturate at MAX_DIM on write
    assign dim_sat = (cfg_wdata > MAX_DIM) ? MAX_DIM : cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode   <= MODE_OPAQUE;
            cfg_reg.width  <= 13'd640;
            cfg_reg.height <= 13'd480;
            cfg_reg.pitch  <= 13'd640;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_BLEND_MODE:    cfg_reg.mode   <= cfg_wdata[MODE_W-1:0];
                REG_WINDOW_WIDTH:  cfg_reg.width  <= dim_sat;
                REG_WINDOW_HEIGHT: cfg_reg.height <= dim_sat;
                REG_SCREEN_PITCH:  cfg_reg.pitch  <= dim_sat;
                default:           cfg_reg        <= cfg_reg;
            endcase
        end
    end

    // front: one job per accepted advance, state update per item
    cor_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_op      (s_tuser[0]),
        .in_cx      (s_tdata[15:0]),
        .in_cy      (s_tdata[31:16]),
        .in_radius  (s_tdata[46:32]),
        .in_colour  (s_tdata[54:47]),
        .blend_mode (cfg_reg.mode),
        .q_status   (q_status),
        .in_ready   (s_tready),
        .push       (push),
        .push_job   (push_job)
    );

    cor_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // back: pops a job when its last point enters the pipe
    cor_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .head_job    (head_job),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_visible (out_visible),
        .out_offset  (out_offset),
        .out_colour  (out_colour),
        .out_mode    (out_mode),
        .out_last    (out_last),
        .out_fin     (out_fin)
    );

    assign m_tdata = {5'b0, out_fin, out_mode, out_colour, out_offset};
    assign m_tuser = out_visible;
    assign m_tlast = out_last;

`ifndef SYNTHESIS
    // front must never push into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("job pushed into full queue");

    // back must never pop an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("job popped from empty queue");

    // a clipped point carries a zero offset
    a_clip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[23:0] == 24'd0))
        else $error("invisible point with nonzero offset");

    // a single-result job always ends its run at once
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_job.single) |-> (head_job.fin))
        else $error("single job without finished flag");
`endif

endmodule
`default_nettype wire

// ===== rtl/cor_front.sv =====
// Front end: accepts items, runs Bresenham's circle recurrence, queues one job per advance.
// Depends on cor_pkg.
`default_nettype none
module cor_front (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          in_valid,
    input  wire                          in_op,
    input  wire [cor_pkg::COORD_W-1:0]   in_cx,
    input  wire [cor_pkg::COORD_W-1:0]   in_cy,
    input  wire [cor_pkg::RAD_W-1:0]     in_radius,
    input  wire [cor_pkg::COLOUR_W-1:0]  in_colour,
    input  wire [cor_pkg::MODE_W-1:0]    blend_mode,
    input  cor_pkg::q_status_t           q_status,
    output logic                         in_ready,
    output logic                         push,
    output cor_pkg::job_t                push_job
);
    import cor_pkg::*;

    phase_t                    phase_reg, phase_next;
    logic [COORD_W-1:0]        cx_reg, cx_next;
    logic [COORD_W-1:0]        cy_reg, cy_next;
    logic [COLOUR_W-1:0]       colour_reg, colour_next;
    logic [OFFS_W-1:0]         minor_reg, minor_next;
    logic [OFFS_W-1:0]         major_reg, major_next;
    logic [DEC_W-1:0]          dec_reg, dec_next;

    logic                      accept;
    logic [MODE_W-1:0]         mode_eff;
    logic [DEC_W-1:0]          diff;
    logic [OFFS_W-1:0]         minor_step, major_step;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign mode_eff = (blend_mode == MODE_RSVD) ? MODE_OPAQUE : blend_mode;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            cx_reg     <= '0;
            cy_reg     <= '0;
            colour_reg <= '0;
            minor_reg  <= '0;
            major_reg  <= '0;
            dec_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            colour_reg <= colour_next;
            minor_reg  <= minor_next;
            major_reg  <= major_next;
            dec_reg    <= dec_next;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        colour_next = colour_reg;
        minor_next  = minor_reg;
        major_next  = major_reg;
        dec_next    = dec_reg;
        push        = 1'b0;

        push_job.blank  = 1'b0;
        push_job.single = 1'b0;
        push_job.fin    = 1'b0;
        push_job.cx     = cx_reg;
        push_job.cy     = cy_reg;
        push_job.minor  = minor_reg;
        push_job.major  = major_reg;
        push_job.colour = colour_reg;
        push_job.mode   = mode_eff;

        // loop recurrence, used in PH_LOOP
        diff       = {{(DEC_W-OFFS_W){1'b0}}, minor_reg} - {{(DEC_W-OFFS_W){1'b0}}, major_reg};
        minor_step = minor_reg + OFFS_W'(1);
        major_step = dec_reg[DEC_W-1] ? major_reg : (major_reg - OFFS_W'(1));

        if (accept) begin
            if (in_op == OP_START) begin
                cx_next     = in_cx;
                cy_next     = in_cy;
                colour_next = in_colour;
                minor_next  = '0;
                major_next  = {{(OFFS_W-RAD_W){1'b0}}, in_radius};
                dec_next    = DEC_INIT - {{(DEC_W-RAD_W-1){1'b0}}, in_radius, 1'b0};
                phase_next  = (in_radius <= RAD_W'(1)) ? PH_SINGLE : PH_LOOP;
            end else begin
                push = 1'b1;
                case (phase_reg)
                    PH_IDLE: begin
                        push_job.blank  = 1'b1;
                        push_job.single = 1'b1;
                        push_job.fin    = 1'b1;
                        push_job.colour = '0;
                        push_job.mode   = MODE_OPAQUE;
                    end
                    PH_SINGLE: begin
                        push_job.single = 1'b1;
                        push_job.fin    = 1'b1;
                        push_job.minor  = '0;
                        push_job.major  = '0;
                        phase_next      = PH_IDLE;
                    end
                    PH_CLOSE: begin
                        push_job.fin = 1'b1;
                        phase_next   = PH_IDLE;
                    end
                    PH_LOOP: begin
                        if (!dec_reg[DEC_W-1]) begin
                            dec_next = dec_reg + {diff[DEC_W-3:0], 2'b00} + DEC_DIAG;
                        end else begin
                            dec_next = dec_reg
                                     + {{(DEC_W-OFFS_W-2){1'b0}}, minor_reg, 2'b00} + DEC_AXIS;
                        end
                        minor_next = minor_step;
                        major_next = major_step;
                        if (minor_step > major_step) begin
                            push_job.fin = 1'b1;
                            phase_next   = PH_IDLE;
                        end else if (minor_step == major_step) begin
                            phase_next   = PH_CLOSE;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cor_queue.sv =====
// Two-entry job queue between the front end and the point sequencer.
// Depends on cor_pkg.
`default_nettype none
module cor_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  cor_pkg::job_t       push_job,
    input  wire                 pop,
    output cor_pkg::job_t       head_job,
    output cor_pkg::q_status_t  status
);
    import cor_pkg::*;

    job_t        entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cor_back.sv =====
// Back end: expands queued jobs into points, clips them, forms row*pitch+col, output register.
// Depends on cor_pkg.
`default_nettype none
module cor_back (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  cor_pkg::cfg_t                cfg,
    input  cor_pkg::job_t                head_job,
    input  cor_pkg::q_status_t           q_status,
    output logic                         pop,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic                         out_visible,
    output logic [cor_pkg::POFS_W-1:0]   out_offset,
    output logic [cor_pkg::COLOUR_W-1:0] out_colour,
    output logic [cor_pkg::MODE_W-1:0]   out_mode,
    output logic                         out_last,
    output logic                         out_fin
);
    import cor_pkg::*;

    typedef struct packed {
        logic                visible;
        logic [PIX_W-1:0]    col;
        logic [PIX_W-1:0]    row;
        logic [COLOUR_W-1:0] colour;
        logic [MODE_W-1:0]   mode;
        logic                last;
        logic                fin;
    } pt_t;

    function automatic logic in_win(input logic [CRD_X_W-1:0] v, input logic [DIM_W-1:0] lim);
        in_win = !v[CRD_X_W-1] && (v < {{(CRD_X_W-DIM_W){1'b0}}, lim});
    endfunction

    logic [PT_W-1:0]      pt_idx_reg, pt_idx_next;
    logic                 s1_valid_reg;
    pt_t                  s1_reg, s1_next;
    logic                 out_valid_reg;

    logic                 out_can, s1_can, issue, last_pt;
    logic [OFFS_W-1:0]    a_ofs, b_ofs;
    logic [CRD_X_W-1:0]   cx_ext, cy_ext, a_ext, b_ext, col, row;
    logic [POFS_W:0]      prod;
    logic [POFS_W:0]      sum;

    assign out_can = !out_valid_reg || out_ready;
    assign s1_can  = !s1_valid_reg || out_can;
    assign issue   = !q_status.empty && s1_can;
    assign last_pt = head_job.single || (pt_idx_reg == PT_W'(PT_LAST));
    assign pop     = issue && last_pt;
    assign out_valid = out_valid_reg;

    // point k: bit 2 swaps minor/major, bit 0 signs the column, bit 1 the row
    always_comb begin
        a_ofs  = pt_idx_reg[2] ? head_job.major : head_job.minor;
        b_ofs  = pt_idx_reg[2] ? head_job.minor : head_job.major;
        cx_ext = {{(CRD_X_W-COORD_W){head_job.cx[COORD_W-1]}}, head_job.cx};
        cy_ext = {{(CRD_X_W-COORD_W){head_job.cy[COORD_W-1]}}, head_job.cy};
        a_ext  = {{(CRD_X_W-OFFS_W){1'b0}}, a_ofs};
        b_ext  = {{(CRD_X_W-OFFS_W){1'b0}}, b_ofs};
        col    = pt_idx_reg[0] ? (cx_ext + a_ext) : (cx_ext - a_ext);
        row    = pt_idx_reg[1] ? (cy_ext + b_ext) : (cy_ext - b_ext);

        s1_next.visible = !head_job.blank && in_win(col, cfg.width) && in_win(row, cfg.height);
        s1_next.col     = col[PIX_W-1:0];
        s1_next.row     = row[PIX_W-1:0];
        s1_next.colour  = head_job.colour;
        s1_next.mode    = head_job.mode;
        s1_next.last    = last_pt;
        s1_next.fin     = head_job.fin;

        pt_idx_next = pt_idx_reg;
        if (pop) begin
            pt_idx_next = '0;
        end else if (issue) begin
            pt_idx_next = pt_idx_reg + PT_W'(1);
        end
    end

    assign prod = {{(POFS_W+1-PIX_W){1'b0}}, s1_reg.row}
                * {{(POFS_W+1-DIM_W){1'b0}}, cfg.pitch};
    assign sum  = prod + {{(POFS_W+1-PIX_W){1'b0}}, s1_reg.col};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_idx_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pt_idx_reg <= pt_idx_next;
            if (s1_can) begin
                s1_valid_reg <= issue;
            end
            if (out_can) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_reg <= s1_next;
        end
        if (out_can && s1_valid_reg) begin
            out_visible <= s1_reg.visible;
            out_offset  <= s1_reg.visible ? sum[POFS_W-1:0] : '0;
            out_colour  <= s1_reg.colour;
            out_mode    <= s1_reg.mode;
            out_last    <= s1_reg.last;
            out_fin     <= s1_reg.fin;
        end
    end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking bench for circle_outline_rasterizer: drives start/advance items, predicts
// every pixel result in place and compares it field by field. Depends on rtl/cor_pkg.sv
// and the block's top level.
`timescale 1ns / 1ps
module testbench;
    import cor_pkg::*;

    // blend modes that the package leaves unnamed
    localparam logic [MODE_W-1:0] MODE_GLASS_CM = 2'd1;   // glass, colour-major index
    localparam logic [MODE_W-1:0] MODE_GLASS_PM = 2'd2;   // glass, pixel-major index

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [12:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;    // center_x[15:0], center_y[31:16], radius[46:32], colour[54:47]
    logic [0:0]  s_tuser;    // op[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // offset[23:0], colour[31:24], mode[33:32], finished[34]
    logic [0:0]  m_tuser;    // visible[0]
    logic        m_tlast;

    circle_outline_rasterizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 2 ns clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Pixel predictor: own copy of registers and circle state
    // ------------------------------------------------------------------
    typedef struct {
        logic              vis;
        logic [POFS_W-1:0] ofs;
        logic [7:0]        colour;
        logic [1:0]        mode;
        logic              last;
        logic              fin;
    } pixel_t;

    pixel_t      expected_pixels[$];   // oldest first
    pixel_t      step_pixels[$];       // scratch for one advance

    logic [1:0]  cfg_mode;
    int          win_w, win_h, pitch;
    int          cen_col, cen_row;
    logic [7:0]  pen;
    int          minor_ofs, major_ofs;   // 16-bit values
    logic [19:0] decision;
    phase_t      circ_phase;

    // run bookkeeping
    int          err_count;
    int          items_sent;
    int          starts_sent;
    int          pixels_checked;
    int          reg_writes;
    int          circles_done;
    int          closing_steps;
    bit          s_idle_on;
    bit          m_idle_on;

    function automatic pixel_t plot(int col, int row);
        pixel_t p;
        p.vis    = (col >= 0 && col < win_w && row >= 0 && row < win_h);
        p.ofs    = p.vis ? POFS_W'(row * pitch + col) : '0;
        p.colour = pen;
        p.mode   = (cfg_mode == MODE_RSVD) ? MODE_OPAQUE : cfg_mode;
        p.last   = 1'b0;
        p.fin    = 1'b0;
        return p;
    endfunction

    // eight-way symmetry, fixed output order
    function automatic void add_octants(int m, int mj);
        step_pixels.push_back(plot(cen_col - m,  cen_row - mj));
        step_pixels.push_back(plot(cen_col + m,  cen_row - mj));
        step_pixels.push_back(plot(cen_col - m,  cen_row + mj));
        step_pixels.push_back(plot(cen_col + m,  cen_row + mj));
        step_pixels.push_back(plot(cen_col - mj, cen_row - m));
        step_pixels.push_back(plot(cen_col + mj, cen_row - m));
        step_pixels.push_back(plot(cen_col - mj, cen_row + m));
        step_pixels.push_back(plot(cen_col + mj, cen_row + m));
    endfunction

    task automatic reset_model();
        cfg_mode   = MODE_OPAQUE;
        win_w      = 640;
        win_h      = 480;
        pitch      = 640;
        cen_col    = 0;
        cen_row    = 0;
        pen        = '0;
        minor_ofs  = 0;
        major_ofs  = 0;
        decision   = '0;
        circ_phase = PH_IDLE;
    endtask

    // works out the results of one accepted item and queues them
    task automatic rasterize_item(op_t op, logic signed [15:0] cx, logic signed [15:0] cy,
                                  logic [14:0] rad, logic [7:0] colour);
        pixel_t p;
        int     m, mj, d;
        logic   fin;
        fin = 1'b0;
        step_pixels.delete();
        if (op == OP_START) begin
            // a start drops whatever circle was running
            cen_col    = cx;
            cen_row    = cy;
            pen        = colour;
            minor_ofs  = 0;
            major_ofs  = rad;
            decision   = 20'(3 - 2 * int'(rad));
            circ_phase = (rad <= 15'd1) ? PH_SINGLE : PH_LOOP;
            return;
        end
        case (circ_phase)
            PH_IDLE: begin
                // idle answer: blank result, marked last and finished
                p.vis    = 1'b0;
                p.ofs    = '0;
                p.colour = '0;
                p.mode   = MODE_OPAQUE;
                p.last   = 1'b1;
                p.fin    = 1'b1;
                expected_pixels.push_back(p);
                return;
            end
            PH_SINGLE: begin
                step_pixels.push_back(plot(cen_col, cen_row));
                fin        = 1'b1;
                circ_phase = PH_IDLE;
            end
            PH_CLOSE: begin
                add_octants(minor_ofs, major_ofs);
                fin        = 1'b1;
                circ_phase = PH_IDLE;
                closing_steps++;
            end
            default: begin
                m  = minor_ofs;
                mj = major_ofs;
                d  = $signed(decision);
                add_octants(m, mj);
                if (d >= 0) begin
                    d += 4 * (m - mj) + 10;   // diagonal move
                    mj--;
                end else begin
                    d += 4 * m + 6;           // axial move
                end
                m++;
                minor_ofs = m & 'hFFFF;
                major_ofs = mj & 'hFFFF;
                decision  = d[19:0];
                if (m > mj) begin
                    fin        = 1'b1;
                    circ_phase = PH_IDLE;
                end else if (m == mj) begin
                    circ_phase = PH_CLOSE;   // one diagonal step still to come
                end
            end
        endcase
        if (fin)
            circles_done++;
        foreach (step_pixels[i]) begin
            step_pixels[i].fin  = fin;
            step_pixels[i].last = (i == step_pixels.size() - 1);
            expected_pixels.push_back(step_pixels[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Driving side
    // ------------------------------------------------------------------
    // Leaves s_tvalid high after the handshake; the next call (or settle) decides at the
    // following falling edge whether it drops, so valid never sees two updates in one step.
    task automatic send_item(op_t op, logic [15:0] cx, logic [15:0] cy, logic [14:0] rad,
                             logic [7:0] colour);
        int gap;
        gap = s_idle_on ? $urandom_range(0, 16) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, colour, rad, cy, cx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (op == OP_START)
            starts_sent++;
        rasterize_item(op, cx, cy, rad, colour);
    endtask

    task automatic advance_once();
        send_item(OP_ADVANCE, 16'($urandom), 16'($urandom), 15'($urandom), 8'($urandom));
    endtask

    // advance until the predictor says the circle is done, or max_steps run out
    task automatic trace_circle(int max_steps);
        int k;
        k = 0;
        while (circ_phase != PH_IDLE && k < max_steps) begin
            advance_once();
            k++;
        end
    endtask

    // drop valid, wait for every expected pixel, then let the pipe run dry
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [12:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        reg_writes++;
        case (idx)
            REG_BLEND_MODE:    cfg_mode = value[1:0];
            REG_WINDOW_WIDTH:  win_w = (value > MAX_DIM) ? int'(MAX_DIM) : int'(value);
            REG_WINDOW_HEIGHT: win_h = (value > MAX_DIM) ? int'(MAX_DIM) : int'(value);
            default:           pitch = (value > MAX_DIM) ? int'(MAX_DIM) : int'(value);
        endcase
    endtask

    task automatic program_window(logic [1:0] mode, logic [12:0] w, logic [12:0] h,
                                  logic [12:0] p);
        write_reg(REG_BLEND_MODE, 13'(mode));
        write_reg(REG_WINDOW_WIDTH, w);
        write_reg(REG_WINDOW_HEIGHT, h);
        write_reg(REG_SCREEN_PITCH, p);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall per item, checker on every handshake
    // ------------------------------------------------------------------
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aresetn);
        forever begin
            stall = m_idle_on ? $urandom_range(0, 16) : 0;
            @(negedge aclk);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic note_mismatch(string what, longint got, longint want);
        err_count++;
        if (err_count <= 40)
            $display("%0t ns: pixel %0d %s mismatch: got 0x%0h, expected 0x%0h",
                     $time, pixels_checked, what, got, want);
    endtask

    always @(posedge aclk) begin
        pixel_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.vis    = m_tuser[0];
            got.ofs    = m_tdata[23:0];
            got.colour = m_tdata[31:24];
            got.mode   = m_tdata[33:32];
            got.fin    = m_tdata[34];
            got.last   = m_tlast;
            if (expected_pixels.size() == 0) begin
                note_mismatch("unexpected result", m_tdata, 0);
            end else begin
                want = expected_pixels.pop_front();
                if (got.vis !== want.vis)       note_mismatch("visible", got.vis, want.vis);
                if (got.ofs !== want.ofs)       note_mismatch("pixel_offset", got.ofs, want.ofs);
                if (got.colour !== want.colour) note_mismatch("colour", got.colour, want.colour);
                if (got.mode !== want.mode)     note_mismatch("mode", got.mode, want.mode);
                if (got.last !== want.last)     note_mismatch("run_last", got.last, want.last);
                if (got.fin !== want.fin)       note_mismatch("finished", got.fin, want.fin);
            end
            pixels_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // advance with nothing loaded, then radius 0 and 1 (centre pixel only)
    task automatic test_idle_and_tiny_radius();
        advance_once();
        send_item(OP_START, 16'd320, 16'd240, 15'd0, 8'hFF);
        advance_once();
        advance_once();                        // idle again after the single pixel
        send_item(OP_START, 16'd0, 16'd479, 15'd1, 8'h00);
        advance_once();
        settle();
    endtask

    // radius 3 ends with m == M, so the closing diagonal step shows up
    task automatic test_closing_step();
        send_item(OP_START, 16'd100, 16'd100, 15'd3, 8'h5A);
        trace_circle(10);
        settle();
    endtask

    // clipping at every edge, coordinate extremes, restart mid-circle
    task automatic test_restart_and_clipping();
        send_item(OP_START, 16'd0, 16'd0, 15'd10, 8'h3C);
        advance_once();
        advance_once();
        send_item(OP_START, 16'h8000, 16'h7FFF, 15'h7FFF, 8'hFF);
        advance_once();
        advance_once();
        send_item(OP_START, 16'h7FFF, 16'h8000, 15'h4000, 8'h00);
        advance_once();
        send_item(OP_START, 16'd639, 16'd479, 15'd5, 8'hA5);
        trace_circle(10);
        advance_once();                        // one past the end: idle answer
        settle();
    endtask

    // mostly whole circles with random content; some cut short, some pure noise
    task automatic run_random_phase(int budget);
        int stop_at, kind, rad, cx, cy;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            kind      = $urandom_range(0, 9);
            s_idle_on = ($urandom_range(0, 3) != 0);
            m_idle_on = ($urandom_range(0, 3) != 0);
            if (kind == 0) begin
                send_item(op_t'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                          15'($urandom), 8'($urandom));
            end else begin
                rad = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120)
                                                  : $urandom_range(0, 24);
                cx  = $urandom_range(0, win_w + 40) - 20;
                cy  = $urandom_range(0, win_h + 40) - 20;
                send_item(OP_START, 16'(cx), 16'(cy), 15'(rad), 8'($urandom));
                if (kind == 1) begin
                    trace_circle($urandom_range(1, 3));   // next start drops it
                end else begin
                    trace_circle(1000);
                    if (kind == 2)
                        advance_once();
                end
            end
        end
        s_idle_on = 1'b1;
        m_idle_on = 1'b1;
        settle();
    endtask

    // register sweep with random traffic under each setting
    task automatic test_register_sweep(int budget);
        for (int s = 0; s < 7; s++) begin
            case (s)
                0: program_window(MODE_GLASS_CM, 13'd4096, 13'd4096, 13'd4096);
                1: program_window(MODE_GLASS_PM, 13'd8191, 13'd6000, 13'd8191);
                2: program_window(MODE_RSVD, 13'd0, 13'd0, 13'd0);
                3: program_window(MODE_OPAQUE, 13'd1, 13'd1, 13'd1);
                4: program_window(MODE_GLASS_CM, 13'd64, 13'd48, 13'd100);
                default: program_window(2'($urandom_range(0, 3)), 13'($urandom_range(1, 300)),
                                        13'($urandom_range(1, 300)),
                                        13'($urandom_range(0, 8191)));
            endcase
            run_random_phase(budget / 7);
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= REG_BLEND_MODE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_START;
        s_idle_on = 1'b1;
        m_idle_on = 1'b1;
        err_count = 0;
        items_sent = 0;
        starts_sent = 0;
        pixels_checked = 0;
        reg_writes = 0;
        circles_done = 0;
        closing_steps = 0;
        reset_model();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_and_tiny_radius();
        test_closing_step();
        test_restart_and_clipping();
        test_register_sweep(380);

        $display("ran %0d items (%0d starts), checked %0d pixel results, %0d register writes",
                 items_sent, starts_sent, pixels_checked, reg_writes);
        $display("%0d circles completed, %0d of them through the closing diagonal step",
                 circles_done, closing_steps);
        if (err_count == 0)
            $display("** circle_outline_rasterizer: PASSED **");
        else
            $display("** circle_outline_rasterizer: FAILED **");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #1_000_000;
        $display("timeout: %0d pixel results still pending", expected_pixels.size());
        $display("** circle_outline_rasterizer: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cor_pkg.sv
rtl/cor_front.sv
rtl/cor_queue.sv
rtl/cor_back.sv
rtl/circle_outline_rasterizer.sv
sim/testbench.sv
